// ----- hdl/markup_tag_strip_filter_unit_defines.svh -----
// assertion macros for the markup tag strip filter
`ifndef MARKUP_TAG_STRIP_FILTER_UNIT_DEFINES_SVH
`define MARKUP_TAG_STRIP_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MTSF_ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MTSF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MTSF_ASSERT_IMPL(label, prop, msg)
`define MTSF_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ----- hdl/mtsf_pkg.sv -----
// shared constants, types and the tag rendering function of the tag strip filter
`default_nettype none

package mtsf_pkg;

  localparam int TAG_CAPACITY = 20;
  localparam int LEN_W = 5;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
  } rend_t;

  // output bytes for a closed tag, count 0 when the tag has no rendering
  function automatic rend_t render_tag(input logic [7:0] first, input logic [7:0] second,
                                       input logic [7:0] num);
    rend_t r;
    r = '{count: 2'd0, b0: 8'h00, b1: 8'h00};
    if (first == CH_R) begin
      if (second == CH_F_UP) begin
        r = '{count: 2'd2, b0: CH_SPACE, b1: CH_OPEN};
      end else if (second == CH_F_LO) begin
        r = '{count: 2'd2, b0: CH_CLOSE, b1: CH_SPACE};
      end
    end else if (first == CH_C) begin
      case (second)
        CH_A: r = '{count: 2'd1, b0: num, b1: 8'h00};
        CH_G: r = '{count: 2'd1, b0: CH_GT, b1: 8'h00};
        CH_L, CH_N: r = '{count: 2'd1, b0: CH_NL, b1: 8'h00};
        CH_M: r = '{count: 2'd2, b0: CH_NL, b1: CH_NL};
        default: r = '{count: 2'd0, b0: 8'h00, b1: 8'h00};
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/markup_tag_strip_filter_unit.sv -----
// a result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one byte per cycle while the output is not stalled; a two-byte rendering holds
// the input while its second byte waits in the pending register
// a byte that opens, fills or drops a tag produces no beat
// reset (rst, synchronous, active high) leaves the block outside any tag, outputs empty
`default_nettype none
`include "markup_tag_strip_filter_unit_defines.svh"

module markup_tag_strip_filter_unit #(
  parameter int TAG_CAPACITY = mtsf_pkg::TAG_CAPACITY
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast    // last_of_run
);

  localparam logic [mtsf_pkg::LEN_W-1:0] CAP = mtsf_pkg::LEN_W'(TAG_CAPACITY);

  // tag state
  logic                       inside_tag, inside_tag_next;
  logic [7:0]                 tag_first_char, tag_first_char_next;
  logic [7:0]                 tag_second_char, tag_second_char_next;
  logic [mtsf_pkg::LEN_W-1:0] tag_length, tag_length_next;
  logic [7:0]                 number_accum, number_accum_next;
  logic                       digits_open, digits_open_next;

  // result register and pending second byte
  logic       out_valid, out_valid_next;
  logic [7:0] out_byte, out_byte_next;
  logic       out_last, out_last_next;
  logic       pend_valid, pend_valid_next;
  logic [7:0] pend_byte, pend_byte_next;

  logic            accept;
  logic            take;
  mtsf_pkg::rend_t rend;
  logic            is_digit;

  assign take     = out_valid && m_tready;
  assign s_tready = !pend_valid && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

  assign is_digit = (s_tdata >= mtsf_pkg::CH_ZERO) && (s_tdata <= mtsf_pkg::CH_NINE);

  // per-byte tag parsing and rendering
  always_comb begin
    inside_tag_next      = inside_tag;
    tag_first_char_next  = tag_first_char;
    tag_second_char_next = tag_second_char;
    tag_length_next      = tag_length;
    number_accum_next    = number_accum;
    digits_open_next     = digits_open;
    rend = '{count: 2'd0, b0: 8'h00, b1: 8'h00};

    if (s_tdata == mtsf_pkg::CH_LT) begin
      inside_tag_next      = 1'b1;
      tag_first_char_next  = 8'h00;
      tag_second_char_next = 8'h00;
      tag_length_next      = '0;
      number_accum_next    = 8'h00;
      digits_open_next     = 1'b1;
    end else if (s_tdata == mtsf_pkg::CH_GT) begin
      // stray close outside a tag is dropped
      if (inside_tag) begin
        inside_tag_next = 1'b0;
        rend = mtsf_pkg::render_tag(tag_first_char, tag_second_char, number_accum);
      end
    end else if (inside_tag) begin
      // characters past capacity are ignored
      if (tag_length < CAP) begin
        if (tag_length == '0) begin
          tag_first_char_next = s_tdata;
        end else if (tag_length == mtsf_pkg::LEN_W'(1)) begin
          tag_second_char_next = s_tdata;
        end else if (digits_open) begin
          if (is_digit) begin
            number_accum_next = (number_accum << 3) + (number_accum << 1)
                              + (s_tdata - mtsf_pkg::CH_ZERO);
          end else begin
            digits_open_next = 1'b0;
          end
        end
        tag_length_next = tag_length + mtsf_pkg::LEN_W'(1);
      end
    end else begin
      rend = '{count: 2'd1, b0: s_tdata, b1: 8'h00};
    end
  end

  // output register and pending byte movement
  always_comb begin
    out_valid_next  = out_valid && !take;
    out_byte_next   = out_byte;
    out_last_next   = out_last;
    pend_valid_next = pend_valid;
    pend_byte_next  = pend_byte;

    if (take && pend_valid) begin
      out_valid_next  = 1'b1;
      out_byte_next   = pend_byte;
      out_last_next   = 1'b1;
      pend_valid_next = 1'b0;
    end

    if (accept && (rend.count != 2'd0)) begin
      out_valid_next = 1'b1;
      out_byte_next  = rend.b0;
      out_last_next  = (rend.count == 2'd1);
      if (rend.count == 2'd2) begin
        pend_valid_next = 1'b1;
        pend_byte_next  = rend.b1;
      end
    end
  end

  // control and tag state
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag      <= 1'b0;
      tag_first_char  <= 8'h00;
      tag_second_char <= 8'h00;
      tag_length      <= '0;
      number_accum    <= 8'h00;
      digits_open     <= 1'b1;
      out_valid       <= 1'b0;
      pend_valid      <= 1'b0;
    end else begin
      if (accept) begin
        inside_tag      <= inside_tag_next;
        tag_first_char  <= tag_first_char_next;
        tag_second_char <= tag_second_char_next;
        tag_length      <= tag_length_next;
        number_accum    <= number_accum_next;
        digits_open     <= digits_open_next;
      end
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_byte  <= out_byte_next;
    out_last  <= out_last_next;
    pend_byte <= pend_byte_next;
  end

  // checks
  `MTSF_ASSERT_IMPL(a_pend_has_out, !pend_valid || out_valid, "pending byte without output beat")
  `MTSF_ASSERT_IMPL(a_pend_blocks, !pend_valid || !s_tready, "input taken while byte pending")
  `MTSF_ASSERT_IMPL(a_len_cap, tag_length <= CAP, "tag length past capacity")
  `MTSF_ASSERT_NEXT(a_open_tag, accept && (s_tdata == mtsf_pkg::CH_LT), inside_tag && (tag_length == '0), "open bracket did not restart tag")

endmodule

`default_nettype wire
